>>> hdl/quadtree_face_neighbor_lookup_assert.svh
// ----------------------------------------------------------------------------
// quadtree_face_neighbor_lookup_assert.svh
// Assertion macros for the quadtree face neighbor lookup block.
// ----------------------------------------------------------------------------
`ifndef QUADTREE_FACE_NEIGHBOR_LOOKUP_ASSERT_SVH
`define QUADTREE_FACE_NEIGHBOR_LOOKUP_ASSERT_SVH

`ifndef SYNTH

// antecedent holds, consequent holds in the same cycle
`define QFNL_ASSERT_SAME(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("quadtree lookup check failed");

// antecedent holds, consequent holds in the next cycle
`define QFNL_ASSERT_NEXT(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("quadtree lookup check failed");

`else

`define QFNL_ASSERT_SAME(name, clock, reset, ante, cons)
`define QFNL_ASSERT_NEXT(name, clock, reset, ante, cons)

`endif

`endif

>>> hdl/qfnl_pkg.sv
// ----------------------------------------------------------------------------
// qfnl_pkg
// Shared types, codes and constants of the quadtree face neighbor lookup.
// ----------------------------------------------------------------------------
package qfnl_pkg;

  localparam int BASE_LOG2_DEF = 8;
  localparam int MAX_LEVELS    = 8;
  localparam int LEVEL_SLOTS   = 8;

  localparam int COORD_W     = 8;
  localparam int LEVEL_W     = 3;
  localparam int LABEL_W     = 2;
  localparam int CFG_W       = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int NB_W        = COORD_W + 1;
  localparam int KID_W       = COORD_W + 2;

  localparam logic [LABEL_W-1:0] LBL_INACTIVE = 2'd0;
  localparam logic [LABEL_W-1:0] LBL_ACTIVE   = 2'd1;
  localparam logic [LABEL_W-1:0] LBL_UP       = 2'd2;
  localparam logic [LABEL_W-1:0] LBL_DOWN     = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_LOG2  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_LOG2 = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_COUNT = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_LABEL,
    ST_CHILD0,
    ST_CHILD1,
    ST_SECOND
  } state_t;

  typedef struct packed {
    logic               wr;
    logic [LABEL_W-1:0] data;
  } store_req_t;

  function automatic int stride_log2(input int lv, input int b);
    return (lv < b) ? (b - lv) : 0;
  endfunction

  function automatic int level_base(input int lv, input int b);
    int acc;
    acc = 0;
    for (int l = 0; l < lv; l++) begin
      acc = acc + (1 << (2 * stride_log2(l, b)));
    end
    return acc;
  endfunction

endpackage

>>> hdl/qfnl_store.sv
// ----------------------------------------------------------------------------
// qfnl_store
// Single-port label memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module qfnl_store #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                         clk,
  input  qfnl_pkg::store_req_t         req,
  input  logic [ADDR_W-1:0]            addr,
  output logic [qfnl_pkg::LABEL_W-1:0] rdata
);
  import qfnl_pkg::*;

  logic [LABEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[addr] <= req.data;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hdl/quadtree_face_neighbor_lookup.sv
// ----------------------------------------------------------------------------
// quadtree_face_neighbor_lookup
// Multi-level quadtree label store with face neighbor queries.
// ----------------------------------------------------------------------------
// channel   direction  handshake               fields
// item      in         start high, busy low    op level cell_x cell_y axis
//                                              direction label
// result    out        done, one cycle         found neighbor_x neighbor_y
//                                              neighbor_level last
// config    in         cfg_write               cfg_index cfg_data
//
// a write is at most one store write, a query one store read for the neighbor
// label, then up to two dependent child reads, all through one address unit
// and the single memory port, plus a final state for a second result.
// after reset the store is swept to inactive, one entry a cycle, over all
// ((1 << (2*BASE_LOG2+2)) / 3) + 8 entries (87389 at BASE_LOG2 = 8); busy stays
// high meanwhile, config writes are taken at any time.
// results cannot be stalled; done marks each one for a single cycle.
// ----------------------------------------------------------------------------
module quadtree_face_neighbor_lookup #(
  parameter int BASE_LOG2 = qfnl_pkg::BASE_LOG2_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [qfnl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [qfnl_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             start,
  output logic                             busy,
  input  logic                             op,
  input  logic [qfnl_pkg::LEVEL_W-1:0]     level,
  input  logic [qfnl_pkg::COORD_W-1:0]     cell_x,
  input  logic [qfnl_pkg::COORD_W-1:0]     cell_y,
  input  logic                             axis,
  input  logic                             direction,
  input  logic [qfnl_pkg::LABEL_W-1:0]     label,
  output logic                             done,
  output logic                             found,
  output logic [qfnl_pkg::COORD_W-1:0]     neighbor_x,
  output logic [qfnl_pkg::COORD_W-1:0]     neighbor_y,
  output logic [qfnl_pkg::LEVEL_W-1:0]     neighbor_level,
  output logic                             last
);
  import qfnl_pkg::*;

  `include "quadtree_face_neighbor_lookup_assert.svh"

  localparam int STORE_DEPTH = ((1 << (2 * BASE_LOG2 + 2)) / 3) + LEVEL_SLOTS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SUM_W       = ADDR_W + 1;
  localparam logic [CFG_W-1:0] BASE_CAP = CFG_W'(BASE_LOG2);
  localparam logic [CFG_W-1:0] LEVEL_CAP =
    CFG_W'((MAX_LEVELS < LEVEL_SLOTS) ? MAX_LEVELS : LEVEL_SLOTS);

  function automatic logic fits(input logic [KID_W-1:0] v, input logic [CFG_W-1:0] e,
                                input logic [CFG_W-1:0] lv);
    logic [CFG_W-1:0] sh;
    logic             r;
    sh = '0;
    if (e > lv) begin
      sh = e - lv;
      r  = ((v >> sh) == '0);
    end else begin
      r = (v == '0);
    end
    return r;
  endfunction

  state_t state, state_next;

  logic [ADDR_W-1:0] clr_addr;
  logic              clr_last;

  logic [CFG_W-1:0] width_log2, height_log2, level_count;
  logic [CFG_W-1:0] ew, eh, eff_lv;

  logic               q_op, q_axis, q_dir;
  logic [LEVEL_W-1:0] q_lv;
  logic [COORD_W-1:0] q_x, q_y;
  logic [LABEL_W-1:0] q_label;

  logic [NB_W-1:0] nb_x, nb_y, nb_x_next, nb_y_next;
  logic            hit0, hit0_next, hit1;

  logic               done_next, found_next, last_next;
  logic [COORD_W-1:0] nx_next, ny_next;
  logic [LEVEL_W-1:0] nl_next;

  logic               cell_ok, nbr_ok, up_ok, k0_ok, k1_ok;
  logic [COORD_W-1:0] c;
  logic [NB_W-1:0]    c_inc, nc, nbr_x, nbr_y;
  logic [LEVEL_W-1:0] kid_lv;
  logic [KID_W-1:0]   k0x, k0y, k1x, k1y;

  logic [KID_W-1:0]   au_x, au_y;
  logic [LEVEL_W-1:0] au_lv;
  logic [SUM_W-1:0]   au_sum;
  logic [ADDR_W-1:0]  base_tab [LEVEL_SLOTS];
  logic [CFG_W-1:0]   stride_tab [LEVEL_SLOTS];

  store_req_t         req;
  logic [ADDR_W-1:0]  mem_addr;
  logic [LABEL_W-1:0] rdata;

  for (genvar g = 0; g < LEVEL_SLOTS; g++) begin : g_tab
    assign base_tab[g]   = ADDR_W'(level_base(g, BASE_LOG2));
    assign stride_tab[g] = CFG_W'(stride_log2(g, BASE_LOG2));
  end

  // effective register values
  assign ew = (width_log2 > BASE_CAP) ? BASE_CAP : width_log2;
  assign eh = (height_log2 > BASE_CAP) ? BASE_CAP : height_log2;
  assign eff_lv = (level_count == '0) ? CFG_W'(1) :
                  (level_count > LEVEL_CAP) ? LEVEL_CAP : level_count;

  assign cell_ok = ({1'b0, q_lv} < eff_lv) &&
                   fits({2'b00, q_x}, ew, {1'b0, q_lv}) &&
                   fits({2'b00, q_y}, eh, {1'b0, q_lv});

  // same-level neighbor along the query axis
  assign c      = q_axis ? q_y : q_x;
  assign c_inc  = {1'b0, c} + NB_W'(1);
  assign nc     = q_dir ? c_inc : {1'b0, c - COORD_W'(1)};
  assign nbr_ok = cell_ok && (q_dir ? fits({1'b0, c_inc}, q_axis ? eh : ew, {1'b0, q_lv})
                                    : (c != '0));
  assign nbr_x  = q_axis ? {1'b0, q_x} : nc;
  assign nbr_y  = q_axis ? nc : {1'b0, q_y};

  assign up_ok  = ({1'b0, q_lv} + CFG_W'(1)) < eff_lv;

  // facing children one level down
  assign kid_lv = q_lv - LEVEL_W'(1);
  assign k0x    = {nb_x, q_axis ? 1'b0 : ~q_dir};
  assign k0y    = {nb_y, q_axis ? ~q_dir : 1'b0};
  assign k1x    = {nb_x, q_axis ? 1'b1 : ~q_dir};
  assign k1y    = {nb_y, q_axis ? ~q_dir : 1'b1};
  assign k0_ok  = ({1'b0, kid_lv} < eff_lv) && fits(k0x, ew, {1'b0, kid_lv}) &&
                  fits(k0y, eh, {1'b0, kid_lv});
  assign k1_ok  = ({1'b0, kid_lv} < eff_lv) && fits(k1x, ew, {1'b0, kid_lv}) &&
                  fits(k1y, eh, {1'b0, kid_lv});
  assign hit1   = k1_ok && (rdata == LBL_ACTIVE);

  // shared address unit
  assign au_sum = SUM_W'(base_tab[au_lv]) + (SUM_W'(au_y) << stride_tab[au_lv]) +
                  SUM_W'(au_x);
  assign mem_addr = (state == ST_CLEAR) ? clr_addr :
                    (au_sum < SUM_W'(STORE_DEPTH)) ? au_sum[ADDR_W-1:0] : '0;

  assign clr_last = (clr_addr == ADDR_W'(STORE_DEPTH - 1));
  assign busy     = (state != ST_IDLE);

  qfnl_store #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .req   (req),
    .addr  (mem_addr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_LOOK;
      end
      ST_LOOK: begin
        state_next = (q_op == OP_QUERY && nbr_ok) ? ST_LABEL : ST_IDLE;
      end
      ST_LABEL: begin
        state_next = (rdata == LBL_DOWN && q_lv != '0) ? ST_CHILD0 : ST_IDLE;
      end
      ST_CHILD0: begin
        state_next = ST_CHILD1;
      end
      ST_CHILD1: begin
        state_next = (hit0 && hit1) ? ST_SECOND : ST_IDLE;
      end
      ST_SECOND: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req        = '0;
    au_x       = {2'b00, q_x};
    au_y       = {2'b00, q_y};
    au_lv      = q_lv;
    nb_x_next  = nb_x;
    nb_y_next  = nb_y;
    hit0_next  = hit0;
    done_next  = 1'b0;
    found_next = 1'b0;
    nx_next    = '0;
    ny_next    = '0;
    nl_next    = '0;
    last_next  = 1'b0;
    case (state)
      ST_CLEAR: begin
        req.wr   = 1'b1;
        req.data = LBL_INACTIVE;
      end
      ST_LOOK: begin
        if (q_op == OP_WRITE) begin
          req.wr   = cell_ok;
          req.data = q_label;
        end else begin
          au_x      = {1'b0, nbr_x};
          au_y      = {1'b0, nbr_y};
          nb_x_next = nbr_x;
          nb_y_next = nbr_y;
          if (!nbr_ok) begin
            done_next = 1'b1;
            last_next = 1'b1;
          end
        end
      end
      ST_LABEL: begin
        au_x  = k0x;
        au_y  = k0y;
        au_lv = kid_lv;
        case (rdata)
          LBL_ACTIVE: begin
            done_next  = 1'b1;
            found_next = 1'b1;
            nx_next    = nb_x[COORD_W-1:0];
            ny_next    = nb_y[COORD_W-1:0];
            nl_next    = q_lv;
            last_next  = 1'b1;
          end
          LBL_UP: begin
            done_next = 1'b1;
            last_next = 1'b1;
            if (up_ok) begin
              found_next = 1'b1;
              nx_next    = nb_x[NB_W-1:1];
              ny_next    = nb_y[NB_W-1:1];
              nl_next    = q_lv + LEVEL_W'(1);
            end
          end
          LBL_DOWN: begin
            if (q_lv == '0) begin
              done_next = 1'b1;
              last_next = 1'b1;
            end
          end
          default: begin
            done_next = 1'b1;
            last_next = 1'b1;
          end
        endcase
      end
      ST_CHILD0: begin
        au_x      = k1x;
        au_y      = k1y;
        au_lv     = kid_lv;
        hit0_next = k0_ok && (rdata == LBL_ACTIVE);
      end
      ST_CHILD1: begin
        done_next = 1'b1;
        last_next = 1'b1;
        if (hit0) begin
          found_next = 1'b1;
          nx_next    = k0x[COORD_W-1:0];
          ny_next    = k0y[COORD_W-1:0];
          nl_next    = kid_lv;
          last_next  = ~hit1;
        end else if (hit1) begin
          found_next = 1'b1;
          nx_next    = k1x[COORD_W-1:0];
          ny_next    = k1y[COORD_W-1:0];
          nl_next    = kid_lv;
        end
      end
      ST_SECOND: begin
        done_next  = 1'b1;
        found_next = 1'b1;
        nx_next    = k1x[COORD_W-1:0];
        ny_next    = k1y[COORD_W-1:0];
        nl_next    = kid_lv;
        last_next  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      done        <= 1'b0;
      width_log2  <= CFG_RESET;
      height_log2 <= CFG_RESET;
      level_count <= CFG_RESET;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_WIDTH_LOG2:  width_log2  <= cfg_data;
          REG_HEIGHT_LOG2: height_log2 <= cfg_data;
          REG_LEVEL_COUNT: level_count <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      q_op    <= op;
      q_lv    <= level;
      q_x     <= cell_x;
      q_y     <= cell_y;
      q_axis  <= axis;
      q_dir   <= direction;
      q_label <= label;
    end
    nb_x           <= nb_x_next;
    nb_y           <= nb_y_next;
    hit0           <= hit0_next;
    found          <= found_next;
    neighbor_x     <= nx_next;
    neighbor_y     <= ny_next;
    neighbor_level <= nl_next;
    last           <= last_next;
  end

  `QFNL_ASSERT_SAME(a_empty_is_last, clk, rst, done && !found, last)
  `QFNL_ASSERT_SAME(a_first_of_two, clk, rst, done && !last, found && state == ST_SECOND)
  `QFNL_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && state == ST_LOOK)
  `QFNL_ASSERT_SAME(a_no_result_in_clear, clk, rst, state == ST_CLEAR, !done)

endmodule
